// ----- rtl/pbf_pkg.sv -----
package pbf_pkg;

   // default geometry of the filter
   localparam int NUM_PARTITIONS_DEF     = 4;
   localparam int BITS_PER_PARTITION_DEF = 4096;

   // request beat layout
   localparam int INDEX_FIELDS = 4;
   localparam int IDX_W        = 12;
   localparam int OP_W         = 2;
   localparam int REQ_TDATA_W  = 56;
   localparam int RSP_TDATA_W  = 8;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // fixed-point shift of the reciprocal used for the index reduction
   localparam int RECIP_SHIFT = 24;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      BK_SWEEP,
      BK_RUN,
      BK_EVAL
   } back_state_type;

endpackage

// ----- rtl/pbf_front.sv -----
module pbf_front import pbf_pkg::*; #(
   parameter int NUM_PARTITIONS     = NUM_PARTITIONS_DEF,
   parameter int BITS_PER_PARTITION = BITS_PER_PARTITION_DEF,
   localparam int ADDR_W = $clog2(BITS_PER_PARTITION),
   localparam int CMD_W  = OP_W + 1 + NUM_PARTITIONS * ADDR_W,
   localparam int LVL_W  = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   input  logic                   init_done,
   input  logic [LVL_W-1:0]       q_level,
   output logic                   q_push,
   output logic [CMD_W-1:0]       q_push_data
);

   localparam int RECIP   = (1 << RECIP_SHIFT) / BITS_PER_PARTITION;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = IDX_W + RECIP_W;
   localparam int BPP_W   = $clog2(BITS_PER_PARTITION + 1);
   localparam int MUL_W   = IDX_W + BPP_W;

   logic [IDX_W-1:0]  fld [INDEX_FIELDS];
   op_type            op_in;
   logic              known_op;
   logic              accept;
   logic [LVL_W:0]    inflight;

   logic              va_ff;
   op_type            op_a_ff;
   logic              last_a_ff;
   logic [IDX_W-1:0]  idx_a_ff [NUM_PARTITIONS];
   logic [IDX_W-1:0]  q_a_ff [NUM_PARTITIONS];
   logic [IDX_W-1:0]  q_in [NUM_PARTITIONS];

   logic              vb_ff;
   op_type            op_b_ff;
   logic              last_b_ff;
   logic [ADDR_W-1:0] addr_b_ff [NUM_PARTITIONS];
   logic [ADDR_W-1:0] addr_in [NUM_PARTITIONS];

   // unpack the index fields of a beat
   for (genvar i = 0; i < INDEX_FIELDS; i++) begin : g_fld
      assign fld[i] = req_tdata[OP_W + i*IDX_W +: IDX_W];
   end

   assign op_in = op_type'(req_tdata[OP_W-1:0]);

   // classify: unused op codes are dropped here
   always_comb begin
      unique case (op_in)
         OP_INSERT, OP_QUERY, OP_CLEAR: known_op = 1'b1;
         default:                       known_op = 1'b0;
      endcase
   end

   // credit check: never more beats in flight than the queue can hold
   assign inflight = (LVL_W+1)'(q_level) + (LVL_W+1)'(va_ff) + (LVL_W+1)'(vb_ff);
   assign req_tready = init_done && (inflight < (LVL_W+1)'(QUEUE_DEPTH));
   assign accept = req_tvalid && req_tready;

   // index reduction modulo the partition size, two stages per lane
   for (genvar k = 0; k < NUM_PARTITIONS; k++) begin : g_lane
      logic [PROD_W-1:0] prod;
      logic [MUL_W-1:0]  rem_raw;
      logic [MUL_W-1:0]  rem_fix;

      // quotient estimate, at most one below the true quotient
      assign prod    = PROD_W'(fld[k % INDEX_FIELDS]) * PROD_W'(RECIP);
      assign q_in[k] = IDX_W'(prod >> RECIP_SHIFT);

      // remainder with one correction step
      assign rem_raw = MUL_W'(idx_a_ff[k])
                       - MUL_W'(q_a_ff[k]) * MUL_W'(BITS_PER_PARTITION);
      assign rem_fix = (rem_raw >= MUL_W'(BITS_PER_PARTITION))
                       ? rem_raw - MUL_W'(BITS_PER_PARTITION) : rem_raw;
      assign addr_in[k] = ADDR_W'(rem_fix);
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= accept && known_op;
         vb_ff <= va_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      op_a_ff   <= op_in;
      last_a_ff <= req_tlast;
      op_b_ff   <= op_a_ff;
      last_b_ff <= last_a_ff;
      for (int k = 0; k < NUM_PARTITIONS; k++) begin
         idx_a_ff[k]  <= fld[k % INDEX_FIELDS];
         q_a_ff[k]    <= q_in[k];
         addr_b_ff[k] <= addr_in[k];
      end
   end

   // command into the queue
   assign q_push = vb_ff;

   always_comb begin
      q_push_data[OP_W-1:0] = op_b_ff;
      q_push_data[OP_W]     = last_b_ff;
      for (int k = 0; k < NUM_PARTITIONS; k++) begin
         q_push_data[OP_W + 1 + k*ADDR_W +: ADDR_W] = addr_b_ff[k];
      end
   end

endmodule

// ----- rtl/pbf_queue.sv -----
module pbf_queue import pbf_pkg::*; #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = QUEUE_DEPTH,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int LVL_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              empty,
   output logic [DATA_W-1:0] head_data,
   output logic [LVL_W-1:0]  level
);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [LVL_W-1:0]  level_ff;
   logic [LVL_W-1:0]  level_in;
   logic              do_pop;

   assign empty     = (level_ff == '0);
   assign level     = level_ff;
   assign head_data = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && !empty;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/pbf_back.sv -----
module pbf_back import pbf_pkg::*; #(
   parameter int NUM_PARTITIONS     = NUM_PARTITIONS_DEF,
   parameter int BITS_PER_PARTITION = BITS_PER_PARTITION_DEF,
   localparam int ADDR_W = $clog2(BITS_PER_PARTITION),
   localparam int CMD_W  = OP_W + 1 + NUM_PARTITIONS * ADDR_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  logic [CMD_W-1:0]       q_data,
   output logic                   q_pop,
   output logic                   init_done,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   back_state_type    state_ff;
   back_state_type    state_in;

   op_type            cmd_op;
   logic              cmd_last;
   logic [ADDR_W-1:0] cmd_addr [NUM_PARTITIONS];
   logic [ADDR_W-1:0] mem_addr [NUM_PARTITIONS];
   logic [NUM_PARTITIONS-1:0] rd_bits;

   logic              mem_we;
   logic              mem_wd;
   logic              mem_re;
   logic              sweep_sel;
   logic              out_load;
   logic              eval_done;
   logic              sweep_end;
   logic              eval_match;

   logic [ADDR_W-1:0] cnt_ff;
   logic [ADDR_W-1:0] cnt_in;
   logic              match_ff;
   logic              match_in;
   logic              last_ff;
   logic              init_done_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              present_ff;

   // unpack the command at the queue head
   assign cmd_op   = op_type'(q_data[OP_W-1:0]);
   assign cmd_last = q_data[OP_W];

   for (genvar k = 0; k < NUM_PARTITIONS; k++) begin : g_bank
      logic mem [BITS_PER_PARTITION];
      logic rd_bit_ff;

      assign cmd_addr[k] = q_data[OP_W + 1 + k*ADDR_W +: ADDR_W];
      assign mem_addr[k] = sweep_sel ? cnt_ff : cmd_addr[k];
      assign rd_bits[k]  = rd_bit_ff;

      // one bit bank per partition
      always_ff @(posedge clock) begin
         if (mem_we) begin
            mem[mem_addr[k]] <= mem_wd;
         end
         if (mem_re) begin
            rd_bit_ff <= mem[mem_addr[k]];
         end
      end
   end

   assign sweep_end  = (cnt_ff == ADDR_W'(BITS_PER_PARTITION - 1));
   assign eval_match = match_ff && (&rd_bits);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_SWEEP: begin
            if (sweep_end) begin
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (!q_empty) begin
               if (cmd_op == OP_QUERY) begin
                  state_in = BK_EVAL;
               end else if (cmd_op == OP_CLEAR) begin
                  state_in = BK_SWEEP;
               end
            end
         end
         BK_EVAL: begin
            if (eval_done) begin
               state_in = BK_RUN;
            end
         end
         default: state_in = BK_SWEEP;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_wd    = 1'b0;
      mem_re    = 1'b0;
      sweep_sel = 1'b0;
      out_load  = 1'b0;
      eval_done = 1'b0;
      unique case (state_ff)
         BK_SWEEP: begin
            mem_we    = 1'b1;
            sweep_sel = 1'b1;
         end
         BK_RUN: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (cmd_op)
                  OP_INSERT: begin
                     mem_we = 1'b1;
                     mem_wd = 1'b1;
                  end
                  OP_QUERY: mem_re = 1'b1;
                  default:  ;
               endcase
            end
         end
         BK_EVAL: begin
            out_load  = last_ff && (!rsp_valid_ff || rsp_tready);
            eval_done = !last_ff || out_load;
         end
         default: ;
      endcase
   end

   // sweep counter, running match flag, result slot
   always_comb begin
      cnt_in   = cnt_ff;
      match_in = match_ff;
      if (state_ff == BK_SWEEP) begin
         cnt_in = sweep_end ? '0 : cnt_ff + 1'b1;
      end
      if (q_pop && (cmd_op == OP_CLEAR)) begin
         match_in = 1'b1;
      end
      if (eval_done) begin
         match_in = last_ff ? 1'b1 : eval_match;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_SWEEP;
         cnt_ff       <= '0;
         match_ff     <= 1'b1;
         init_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         match_ff     <= match_in;
         rsp_valid_ff <= rsp_valid_in;
         if ((state_ff == BK_SWEEP) && sweep_end) begin
            init_done_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (q_pop && (cmd_op == OP_QUERY)) begin
         last_ff <= cmd_last;
      end
      if (out_load) begin
         present_ff <= eval_match;
      end
   end

   assign init_done  = init_done_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(present_ff);

endmodule

// ----- rtl/partitioned_bloom_filter_core.sv -----
// Partitioned Bloom filter with one bit bank per partition. Each request beat
// carries an op code and one precomputed bit index per partition (hashing is
// done upstream); indices are reduced modulo BITS_PER_PARTITION, and partition
// k uses index field k mod 4. Insert sets the addressed bits, query ANDs them
// into a running flag and returns present on the beat with tlast set, clear
// zeroes every bank and rearms the flag; op code 3 is dropped. The front end
// takes at most one beat per cycle into a two-stage index pipeline feeding a
// four-entry command queue, with no more than four commands in flight. The
// back end, which owns the single port of each bank, does an insert in its
// run state, a query as a read then an evaluate step, and a clear as a sweep
// of every address, so sustained rate is set by that port. After reset a
// clearing pass over every address runs with req_tready held low.
module partitioned_bloom_filter_core import pbf_pkg::*; #(
   parameter int NUM_PARTITIONS     = NUM_PARTITIONS_DEF,
   parameter int BITS_PER_PARTITION = BITS_PER_PARTITION_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // operation, index_0..index_3, zero pad
   input  logic                   req_tlast,   // last_word
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // present, zero pad
);

   localparam int ADDR_W = $clog2(BITS_PER_PARTITION);
   localparam int CMD_W  = OP_W + 1 + NUM_PARTITIONS * ADDR_W;
   localparam int LVL_W  = $clog2(QUEUE_DEPTH + 1);

   logic             init_done;
   logic             q_push;
   logic [CMD_W-1:0] q_push_data;
   logic             q_pop;
   logic             q_empty;
   logic [CMD_W-1:0] q_head;
   logic [LVL_W-1:0] q_level;

   // accept and reduce indices
   pbf_front #(
      .NUM_PARTITIONS     (NUM_PARTITIONS),
      .BITS_PER_PARTITION (BITS_PER_PARTITION)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .init_done   (init_done),
      .q_level     (q_level),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // command queue
   pbf_queue #(
      .DATA_W (CMD_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_data (q_head),
      .level     (q_level)
   );

   // bit banks and result
   pbf_back #(
      .NUM_PARTITIONS     (NUM_PARTITIONS),
      .BITS_PER_PARTITION (BITS_PER_PARTITION)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_head),
      .q_pop      (q_pop),
      .init_done  (init_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/pbf_checker.sv -----
module pbf_checker import pbf_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // clearing pass after reset holds off requests
   a_ready_low_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high right after reset");

   // no result beat right after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // stalled request beat stays offered
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid)
      else $error("stalled request beat withdrawn");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // only the present bit may be set
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_TDATA_W-1:1] == '0))
      else $error("result pad bits not zero");

endmodule

bind partitioned_bloom_filter_core pbf_checker u_pbf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
